// File: hw/rtl/quadratic_root_solver_macros.svh
// Assertion macros used by the checker file.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic_root_solver check failed");

// The consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic_root_solver check failed");

`endif

// File: hw/rtl/qrs_pkg.sv
package qrs_pkg;

    typedef enum logic [1:0] {
        KIND_COMPLEX  = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_DISTINCT = 2'd2
    } root_kind_t;

endpackage

// File: hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt #(
    parameter int RW  = 34,
    parameter int SBW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   rad,
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [SBW-1:0]    out_sb
);

    logic              v_w    [RW+1];
    logic [2*RW-1:0]   rad_w  [RW+1];
    logic [RW+1:0]     rem_w  [RW+1];
    logic [RW-1:0]     root_w [RW+1];
    logic [SBW-1:0]    sb_w   [RW+1];

    assign v_w[0]    = in_valid;
    assign rad_w[0]  = rad;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign sb_w[0]   = in_sb;

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic              v_reg;
        logic [2*RW-1:0]   rad_reg;
        logic [RW+1:0]     rem_reg;
        logic [RW-1:0]     root_reg;
        logic [SBW-1:0]    sb_reg;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic              take;
        logic [RW+1:0]     rem_next;
        logic [RW-1:0]     root_next;

        always_comb
        begin
            rem_sh    = {rem_w[s][RW-1:0], rad_w[s][2*RW-1 -: 2]};
            trial     = {root_w[s], 2'b01};
            take      = rem_sh >= trial;
            rem_next  = take ? (rem_sh - trial) : rem_sh;
            root_next = {root_w[s][RW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg  <= rad_w[s] << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                sb_reg   <= sb_w[s];
            end
        end

        assign v_w[s+1]    = v_reg;
        assign rad_w[s+1]  = rad_reg;
        assign rem_w[s+1]  = rem_reg;
        assign root_w[s+1] = root_reg;
        assign sb_w[s+1]   = sb_reg;
    end

    assign out_valid = v_w[RW];
    assign root      = root_w[RW];
    assign out_sb    = sb_w[RW];

endmodule

// File: hw/rtl/qrs_div.sv
// Pipelined restoring divider, two numerators over one divisor, one
// quotient bit per stage.
module qrs_div #(
    parameter int NW  = 50,
    parameter int DW  = 33,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num_a,
    input  logic [NW-1:0]   num_b,
    input  logic [DW-1:0]   den,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [NW-1:0]   quo_a,
    output logic [NW-1:0]   quo_b,
    output logic [SBW-1:0]  out_sb
);

    logic            v_w   [NW+1];
    logic [NW-1:0]   nq_w  [NW+1][2];
    logic [DW-1:0]   rem_w [NW+1][2];
    logic [DW-1:0]   den_w [NW+1];
    logic [SBW-1:0]  sb_w  [NW+1];

    assign v_w[0]      = in_valid;
    assign nq_w[0][0]  = num_a;
    assign nq_w[0][1]  = num_b;
    assign rem_w[0][0] = '0;
    assign rem_w[0][1] = '0;
    assign den_w[0]    = den;
    assign sb_w[0]     = in_sb;

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic            v_reg;
        logic [DW-1:0]   den_reg;
        logic [SBW-1:0]  sb_reg;

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [NW-1:0]  nq_reg;
            logic [DW-1:0]  rem_reg;
            logic [DW:0]    rem_sh;
            logic [DW:0]    diff;
            logic           ge;

            always_comb
            begin
                rem_sh = {rem_w[s][l], nq_w[s][l][NW-1]};
                diff   = rem_sh - {1'b0, den_w[s]};
                ge     = rem_sh >= {1'b0, den_w[s]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg  <= {nq_w[s][l][NW-2:0], ge};
                    rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                end
            end

            assign nq_w[s+1][l]  = nq_reg;
            assign rem_w[s+1][l] = rem_reg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg <= den_w[s];
                sb_reg  <= sb_w[s];
            end
        end

        assign v_w[s+1]   = v_reg;
        assign den_w[s+1] = den_reg;
        assign sb_w[s+1]  = sb_reg;
    end

    assign out_valid = v_w[NW];
    assign quo_a     = nq_w[NW][0];
    assign quo_b     = nq_w[NW][1];
    assign out_sb    = sb_w[NW];

endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Quadratic root solver for a*x^2 + b*x + c with signed fixed-point
// coefficients (COEF_WIDTH bits, FRAC_BITS fraction bits). Each beat returns
// the centre -b/(2a) and the spread floor(sqrt(|b*b-4ac|))/(2a), both
// truncated toward zero and saturated to the coefficient format, with the
// roots being centre +/- spread (spread imaginary when root_kind says
// complex). A zero quadratic coefficient sets degenerate and forces centre,
// spread and saturated to zero while root_kind still classifies the
// discriminant. The block takes one beat per cycle unless a finished result
// waits in the output register and is not taken; the square root resolves
// one result bit per stage, and the divider resolves one quotient bit per
// stage.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COEF_WIDTH-1:0]  centre,
    output logic signed [COEF_WIDTH-1:0]  spread,
    output logic [1:0]                    root_kind,
    output logic                          degenerate,
    output logic                          saturated
);

    localparam int W   = COEF_WIDTH;
    localparam int RW  = W + 2;
    localparam int NW  = W + 2 + FRAC_BITS;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * W + 3;
    localparam int SB1 = 2 * W + 4;
    localparam int SB2 = 5;

    // The whole pipeline moves together; it holds only when a finished
    // result sits in the output register and is not being taken.
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage 1: capture the coefficients.
    logic          v1_reg;
    logic [W-1:0]  a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= coef_a;
            b1_reg <= coef_b;
            c1_reg <= coef_c;
        end
    end

    // Stage 2: sign and magnitude, then the two products b*b and a*c.
    logic          na1, nb1, nc1;
    logic [W-1:0]  ma1, mb1, mc1;

    always_comb
    begin
        na1 = a1_reg[W-1];
        nb1 = b1_reg[W-1];
        nc1 = c1_reg[W-1];
        ma1 = na1 ? (~a1_reg + 1'b1) : a1_reg;
        mb1 = nb1 ? (~b1_reg + 1'b1) : b1_reg;
        mc1 = nc1 ? (~c1_reg + 1'b1) : c1_reg;
    end

    logic            v2_reg;
    logic [2*W-1:0]  bb2_reg, ac2_reg;
    logic [W-1:0]    ma2_reg, mb2_reg;
    logic            na2_reg, nb2_reg, nc2_reg, cnz2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb2_reg  <= mb1 * mb1;
            ac2_reg  <= ma1 * mc1;
            ma2_reg  <= ma1;
            mb2_reg  <= mb1;
            na2_reg  <= na1;
            nb2_reg  <= nb1;
            nc2_reg  <= nc1;
            cnz2_reg <= mc1 != '0;
        end
    end

    // Stage 3: discriminant magnitude and its sign. When a and c have
    // opposite signs, -4ac is positive and adds to b*b.
    logic [PW-1:0]         bbx, ac4, dmag_next;
    logic                  dneg_next;
    qrs_pkg::root_kind_t   kind_next;

    always_comb
    begin
        bbx       = {3'b000, bb2_reg};
        ac4       = {1'b0, ac2_reg, 2'b00};
        dneg_next = 1'b0;
        if ((na2_reg != nc2_reg) && (ma2_reg != '0) && cnz2_reg)
        begin
            dmag_next = bbx + ac4;
        end
        else if (bbx >= ac4)
        begin
            dmag_next = bbx - ac4;
        end
        else
        begin
            dmag_next = ac4 - bbx;
            dneg_next = 1'b1;
        end
        if (dneg_next)
        begin
            kind_next = qrs_pkg::KIND_COMPLEX;
        end
        else if (dmag_next == '0)
        begin
            kind_next = qrs_pkg::KIND_EQUAL;
        end
        else
        begin
            kind_next = qrs_pkg::KIND_DISTINCT;
        end
    end

    logic                 v3_reg;
    logic [PW-1:0]        dmag3_reg;
    qrs_pkg::root_kind_t  kind3_reg;
    logic [W-1:0]         ma3_reg, mb3_reg;
    logic                 na3_reg, nb3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag3_reg <= dmag_next;
            kind3_reg <= kind_next;
            ma3_reg   <= ma2_reg;
            mb3_reg   <= mb2_reg;
            na3_reg   <= na2_reg;
            nb3_reg   <= nb2_reg;
        end
    end

    // Square root of the discriminant; the other fields ride alongside.
    logic            sq_valid;
    logic [RW-1:0]   sq_root;
    logic [SB1-1:0]  sq_sb;

    qrs_sqrt #(
        .RW  (RW),
        .SBW (SB1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .rad       ({1'b0, dmag3_reg}),
        .in_sb     ({ma3_reg, mb3_reg, na3_reg, nb3_reg, kind3_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_sb    (sq_sb)
    );

    logic [W-1:0]  ma4, mb4;
    logic          na4, nb4, neg_c4, degen4;
    logic [1:0]    kind4;

    assign ma4    = sq_sb[SB1-1 -: W];
    assign mb4    = sq_sb[W+3 -: W];
    assign na4    = sq_sb[3];
    assign nb4    = sq_sb[2];
    assign kind4  = sq_sb[1:0];
    assign neg_c4 = (mb4 != '0) && (na4 == nb4);
    assign degen4 = ma4 == '0;

    // Both quotients share the divisor 2a.
    logic            dv_valid;
    logic [NW-1:0]   q_centre, q_spread;
    logic [SB2-1:0]  dv_sb;

    qrs_div #(
        .NW  (NW),
        .DW  (DW),
        .SBW (SB2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num_a     (NW'(mb4) << FRAC_BITS),
        .num_b     (NW'(sq_root) << FRAC_BITS),
        .den       ({ma4, 1'b0}),
        .in_sb     ({neg_c4, na4, kind4, degen4}),
        .out_valid (dv_valid),
        .quo_a     (q_centre),
        .quo_b     (q_spread),
        .out_sb    (dv_sb)
    );

    // Output stage: clamp, apply sign, and blank degenerate results.
    localparam logic [NW-1:0] HALF = NW'(1) << (W - 1);

    logic           neg_c5, neg_s5, degen5;
    logic [NW-1:0]  lim_c, lim_s;
    logic           sat_c, sat_s;
    logic [W-1:0]   mag_c, mag_s;

    always_comb
    begin
        neg_c5 = dv_sb[4];
        neg_s5 = dv_sb[3];
        degen5 = dv_sb[0];
        lim_c  = neg_c5 ? HALF : (HALF - 1'b1);
        lim_s  = neg_s5 ? HALF : (HALF - 1'b1);
        sat_c  = q_centre > lim_c;
        sat_s  = q_spread > lim_s;
        mag_c  = sat_c ? lim_c[W-1:0] : q_centre[W-1:0];
        mag_s  = sat_s ? lim_s[W-1:0] : q_spread[W-1:0];
    end

    logic [W-1:0]  centre_reg, spread_reg;
    logic [1:0]    kind_reg;
    logic          degen_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            centre_reg <= degen5 ? '0 : (neg_c5 ? (~mag_c + 1'b1) : mag_c);
            spread_reg <= degen5 ? '0 : (neg_s5 ? (~mag_s + 1'b1) : mag_s);
            kind_reg   <= dv_sb[2:1];
            degen_reg  <= degen5;
            sat_reg    <= !degen5 && (sat_c || sat_s);
        end
    end

    assign out_valid  = out_valid_reg;
    assign centre     = centre_reg;
    assign spread     = spread_reg;
    assign root_kind  = kind_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

endmodule

// File: hw/rtl/qrs_checker.sv
`include "quadratic_root_solver_macros.svh"

module qrs_checker #(
    parameter int COEF_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COEF_WIDTH-1:0]  centre,
    input logic signed [COEF_WIDTH-1:0]  spread,
    input logic [1:0]                    root_kind,
    input logic                          degenerate,
    input logic                          saturated
);

    // A stalled result beat keeps its values.
    `QRS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(centre) && $stable(spread))

    // A degenerate result carries no centre, spread or clamp.
    `QRS_ASSERT_IMPL(a_degen, out_valid && degenerate, centre == '0 && spread == '0 && !saturated)

    // Equal real roots have no spread.
    `QRS_ASSERT_IMPL(a_equal, out_valid && root_kind == qrs_pkg::KIND_EQUAL, spread == '0)

endmodule

bind quadratic_root_solver qrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qrs_checker (.*);
